// ----- rtl/touch_sample_conditioner_top_defines.svh -----
// ----------------------------------------------------------------------------
// touch_sample_conditioner_top_defines
// Assertion macros shared by the touch sample conditioner RTL.
// ----------------------------------------------------------------------------
`ifndef TOUCH_SAMPLE_CONDITIONER_TOP_DEFINES_SVH
`define TOUCH_SAMPLE_CONDITIONER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define TSC_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tsc assertion failed");

// next-cycle implication, checked out of reset
`define TSC_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tsc assertion failed");

`else

`define TSC_ASSERT_IMP(label, ante, cons)
`define TSC_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ----- rtl/tsc_pkg.sv -----
// ----------------------------------------------------------------------------
// tsc_pkg
// Types and constants of the touch sample conditioner.
// ----------------------------------------------------------------------------
package tsc_pkg;

   localparam int PRESENCE_SAMPLES = 3;
   localparam int POSITION_SAMPLES = 8;
   localparam int SAMPLE_BITS      = 12;

   localparam int FRAME_LEN  = PRESENCE_SAMPLES + POSITION_SAMPLES;
   localparam int INDEX_W    = $clog2(FRAME_LEN);
   localparam int MAX_PHASE  = (PRESENCE_SAMPLES > POSITION_SAMPLES) ?
                               PRESENCE_SAMPLES : POSITION_SAMPLES;
   localparam int COUNT_W    = $clog2(MAX_PHASE + 1);

   localparam int VALID_LOW       = 100;
   localparam int VALID_HIGH      = 3900;
   localparam int PRESENCE_NEEDED = 2;

   localparam int SUM_W = $clog2(MAX_PHASE * VALID_HIGH);

   localparam int REG_W       = 12;
   localparam int ORIENT_W    = 3;
   localparam int CSR_INDEX_W = 3;

   localparam int ORIENT_SWAP     = 0;
   localparam int ORIENT_MIRROR_X = 1;
   localparam int ORIENT_MIRROR_Y = 2;

   localparam logic [REG_W-1:0]    CAL_MIN_RESET      = REG_W'(300);
   localparam logic [REG_W-1:0]    CAL_MAX_RESET      = REG_W'(3700);
   localparam logic [REG_W-1:0]    SCREEN_X_MAX_RESET = REG_W'(319);
   localparam logic [REG_W-1:0]    SCREEN_Y_MAX_RESET = REG_W'(239);
   localparam logic [ORIENT_W-1:0] ORIENT_RESET       = '0;

   // divider width for both dividers: dividend wide enough for |(avg - min) * screen_max|
   localparam int DIV_W     = 2 * REG_W;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);
   localparam int PROD_W    = 2 * REG_W + 2;
   localparam int VAL_W     = DIV_W + 3;

   localparam int JOB_DEPTH = 2;
   localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
   localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CAL_X_MIN    = 3'd0,
      CSR_CAL_Y_MIN    = 3'd1,
      CSR_CAL_X_MAX    = 3'd2,
      CSR_CAL_Y_MAX    = 3'd3,
      CSR_SCREEN_X_MAX = 3'd4,
      CSR_SCREEN_Y_MAX = 3'd5,
      CSR_ORIENTATION  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [REG_W-1:0]    cal_x_min;
      logic [REG_W-1:0]    cal_y_min;
      logic [REG_W-1:0]    cal_x_max;
      logic [REG_W-1:0]    cal_y_max;
      logic [REG_W-1:0]    screen_x_max;
      logic [REG_W-1:0]    screen_y_max;
      logic [ORIENT_W-1:0] orientation;
   } cfg_type;

   typedef enum logic {
      JOB_RELEASED,
      JOB_POSITION
   } job_kind_type;

   typedef struct packed {
      job_kind_type       kind;
      logic [COUNT_W-1:0] count;
      logic [SUM_W-1:0]   sum_x;
      logic [SUM_W-1:0]   sum_y;
   } job_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] steps;
      logic [DIV_W-1:0]     dividend;
      logic [REG_W-1:0]     divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_AVG,
      B_MUL,
      B_DIV,
      B_WAIT,
      B_ORIENT,
      B_EMIT
   } back_state_type;

endpackage

// ----- rtl/tsc_front.sv -----
// ----------------------------------------------------------------------------
// tsc_front
// Sample intake: validity check, frame tracking and per-phase accumulation.
// ----------------------------------------------------------------------------
`include "touch_sample_conditioner_top_defines.svh"

module tsc_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  logic [tsc_pkg::SAMPLE_BITS-1:0]  req_raw_x,
   input  logic [tsc_pkg::SAMPLE_BITS-1:0]  req_raw_y,
   output logic                             job_wr_en,
   output tsc_pkg::job_type                 job_wr_data,
   input  logic                             job_full
);
   import tsc_pkg::*;

   logic [INDEX_W-1:0] frame_index_ff, frame_index_in;
   logic [COUNT_W-1:0] valid_count_ff, valid_count_in;
   logic [SUM_W-1:0]   sum_x_ff, sum_x_in;
   logic [SUM_W-1:0]   sum_y_ff, sum_y_in;

   logic               accept;
   logic               sample_ok;
   logic [COUNT_W-1:0] count_next;
   logic [SUM_W-1:0]   sum_x_next;
   logic [SUM_W-1:0]   sum_y_next;

   assign full   = job_full;
   assign accept = push && !job_full;

   assign sample_ok = (32'(req_raw_x) > VALID_LOW) && (32'(req_raw_x) < VALID_HIGH) &&
                      (32'(req_raw_y) > VALID_LOW) && (32'(req_raw_y) < VALID_HIGH);

   assign count_next = valid_count_ff + COUNT_W'(sample_ok);
   assign sum_x_next = sum_x_ff + (sample_ok ? SUM_W'(req_raw_x) : '0);
   assign sum_y_next = sum_y_ff + (sample_ok ? SUM_W'(req_raw_y) : '0);

   always_comb begin
      frame_index_in    = frame_index_ff;
      valid_count_in    = valid_count_ff;
      sum_x_in          = sum_x_ff;
      sum_y_in          = sum_y_ff;
      job_wr_en         = 1'b0;
      job_wr_data.kind  = JOB_RELEASED;
      job_wr_data.count = count_next;
      job_wr_data.sum_x = sum_x_next;
      job_wr_data.sum_y = sum_y_next;
      if (accept) begin
         if (frame_index_ff < INDEX_W'(PRESENCE_SAMPLES)) begin
            if (frame_index_ff == INDEX_W'(PRESENCE_SAMPLES - 1)) begin
               // end of presence check: phase sums restart either way
               valid_count_in = '0;
               sum_x_in       = '0;
               sum_y_in       = '0;
               if (32'(count_next) < PRESENCE_NEEDED) begin
                  frame_index_in = '0;
                  job_wr_en      = 1'b1;
               end else begin
                  frame_index_in = frame_index_ff + 1'b1;
               end
            end else begin
               valid_count_in = count_next;
               sum_x_in       = sum_x_next;
               sum_y_in       = sum_y_next;
               frame_index_in = frame_index_ff + 1'b1;
            end
         end else if (frame_index_ff < INDEX_W'(FRAME_LEN - 1)) begin
            valid_count_in = count_next;
            sum_x_in       = sum_x_next;
            sum_y_in       = sum_y_next;
            frame_index_in = frame_index_ff + 1'b1;
         end else begin
            job_wr_en        = 1'b1;
            job_wr_data.kind = JOB_POSITION;
            valid_count_in   = '0;
            sum_x_in         = '0;
            sum_y_in         = '0;
            frame_index_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_index_ff <= '0;
         valid_count_ff <= '0;
         sum_x_ff       <= '0;
         sum_y_ff       <= '0;
      end else begin
         frame_index_ff <= frame_index_in;
         valid_count_ff <= valid_count_in;
         sum_x_ff       <= sum_x_in;
         sum_y_ff       <= sum_y_in;
      end
   end

   `TSC_ASSERT_IMP(a_index_in_frame, 1'b1, frame_index_ff < INDEX_W'(FRAME_LEN))
   `TSC_ASSERT_NXT(a_job_ends_frame, job_wr_en, frame_index_ff == '0)

endmodule

// ----- rtl/tsc_job_fifo.sv -----
// ----------------------------------------------------------------------------
// tsc_job_fifo
// Short job queue between the sample front end and the arithmetic back end.
// ----------------------------------------------------------------------------
`include "touch_sample_conditioner_top_defines.svh"

module tsc_job_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  tsc_pkg::job_type wr_data,
   output logic             full,
   input  logic             rd_en,
   output tsc_pkg::job_type rd_data,
   output logic             empty
);
   import tsc_pkg::*;

   job_type              mem_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [JOB_CNT_W-1:0] count_ff, count_in;
   logic                 do_wr;
   logic                 do_rd;

   assign full    = (count_ff == JOB_CNT_W'(JOB_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `TSC_ASSERT_IMP(a_no_overflow, wr_en, count_ff < JOB_CNT_W'(JOB_DEPTH))

endmodule

// ----- rtl/tsc_divider.sv -----
// ----------------------------------------------------------------------------
// tsc_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsc_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  tsc_pkg::div_req_type req,
   output tsc_pkg::div_rsp_type rsp
);
   import tsc_pkg::*;

   logic [REG_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [REG_W-1:0]     divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;

   logic [REG_W:0]       trial;
   logic [REG_W:0]       trial_sub;
   logic                 fits;

   // dividend bits leave at the top of quo_ff, quotient bits enter at the bottom
   assign trial     = {rem_ff, quo_ff[DIV_W-1]};
   assign fits      = (trial >= {1'b0, divisor_ff});
   assign trial_sub = trial - {1'b0, divisor_ff};

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      if (req.start) begin
         rem_in     = '0;
         quo_in     = req.dividend;
         divisor_in = req.divisor;
         count_in   = req.steps;
      end else if (count_ff != '0) begin
         rem_in   = fits ? trial_sub[REG_W-1:0] : trial[REG_W-1:0];
         quo_in   = {quo_ff[DIV_W-2:0], fits};
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rsp.busy     = (count_ff != '0);
   assign rsp.quotient = quo_ff;

endmodule

// ----- rtl/tsc_back.sv -----
// ----------------------------------------------------------------------------
// tsc_back
// Job sequencer: averaging, calibration scaling, orientation and result hold.
// ----------------------------------------------------------------------------
`include "touch_sample_conditioner_top_defines.svh"

module tsc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  tsc_pkg::cfg_type           cfg,
   input  tsc_pkg::job_type           job_rd_data,
   input  logic                       job_empty,
   output logic                       job_rd_en,
   output tsc_pkg::div_req_type       div_x_req,
   input  tsc_pkg::div_rsp_type       div_x_rsp,
   output tsc_pkg::div_req_type       div_y_req,
   input  tsc_pkg::div_rsp_type       div_y_rsp,
   output logic                       empty,
   input  logic                       pop,
   output logic                       rsp_pressed,
   output logic [tsc_pkg::REG_W-1:0]  rsp_point_x,
   output logic [tsc_pkg::REG_W-1:0]  rsp_point_y
);
   import tsc_pkg::*;

   function automatic logic [REG_W-1:0] clamp_to(input logic signed [VAL_W-1:0] v,
                                                 input logic [REG_W-1:0] hi);
      logic signed [VAL_W-1:0] hi_v;
      hi_v = $signed(VAL_W'(hi));
      if (v < 0) begin
         return '0;
      end else if (v > hi_v) begin
         return hi;
      end else begin
         return v[REG_W-1:0];
      end
   endfunction

   back_state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0]  avg_x_ff, avg_x_in;
   logic [SAMPLE_BITS-1:0]  avg_y_ff, avg_y_in;
   logic signed [PROD_W-1:0] prod_x_ff, prod_x_in;
   logic signed [PROD_W-1:0] prod_y_ff, prod_y_in;
   logic signed [VAL_W-1:0] sx_ff, sx_in;
   logic signed [VAL_W-1:0] sy_ff, sy_in;
   logic                    res_pressed_ff, res_pressed_in;
   logic [REG_W-1:0]        res_x_ff, res_x_in;
   logic [REG_W-1:0]        res_y_ff, res_y_in;
   logic                    out_valid_ff, out_valid_in;
   logic                    out_pressed_ff;
   logic [REG_W-1:0]        out_x_ff;
   logic [REG_W-1:0]        out_y_ff;

   logic                    job_avail;
   logic                    range_ok;
   logic                    job_ok;
   logic                    div_done;
   logic                    out_free;
   logic [REG_W-1:0]        x_range;
   logic [REG_W-1:0]        y_range;
   logic signed [REG_W:0]   diff_x;
   logic signed [REG_W:0]   diff_y;
   logic signed [REG_W:0]   scr_x_s;
   logic signed [REG_W:0]   scr_y_s;
   logic signed [PROD_W-1:0] neg_x;
   logic signed [PROD_W-1:0] neg_y;
   logic [DIV_W-1:0]        mag_x;
   logic [DIV_W-1:0]        mag_y;
   logic signed [VAL_W-1:0] qx;
   logic signed [VAL_W-1:0] qy;
   logic signed [VAL_W-1:0] ox, oy, mx, my;
   logic signed [VAL_W-1:0] scr_x_v;
   logic signed [VAL_W-1:0] scr_y_v;

   assign job_avail = !job_empty;
   assign range_ok  = (cfg.cal_x_max > cfg.cal_x_min) && (cfg.cal_y_max > cfg.cal_y_min);
   assign job_ok    = (job_rd_data.kind == JOB_POSITION) && (job_rd_data.count != '0) &&
                      range_ok;
   assign div_done  = !div_x_rsp.busy && !div_y_rsp.busy;
   assign out_free  = !out_valid_ff || pop;
   assign x_range   = cfg.cal_x_max - cfg.cal_x_min;
   assign y_range   = cfg.cal_y_max - cfg.cal_y_min;

   assign diff_x  = $signed((REG_W+1)'(avg_x_ff)) - $signed({1'b0, cfg.cal_x_min});
   assign diff_y  = $signed((REG_W+1)'(avg_y_ff)) - $signed({1'b0, cfg.cal_y_min});
   assign scr_x_s = $signed({1'b0, cfg.screen_x_max});
   assign scr_y_s = $signed({1'b0, cfg.screen_y_max});

   // truncating signed division: divide magnitudes, restore the sign
   assign neg_x = -prod_x_ff;
   assign neg_y = -prod_y_ff;
   assign mag_x = prod_x_ff[PROD_W-1] ? neg_x[DIV_W-1:0] : prod_x_ff[DIV_W-1:0];
   assign mag_y = prod_y_ff[PROD_W-1] ? neg_y[DIV_W-1:0] : prod_y_ff[DIV_W-1:0];
   assign qx    = $signed(VAL_W'(div_x_rsp.quotient));
   assign qy    = $signed(VAL_W'(div_y_rsp.quotient));

   assign scr_x_v = $signed(VAL_W'(cfg.screen_x_max));
   assign scr_y_v = $signed(VAL_W'(cfg.screen_y_max));
   assign ox      = cfg.orientation[ORIENT_SWAP] ? sy_ff : sx_ff;
   assign oy      = cfg.orientation[ORIENT_SWAP] ? sx_ff : sy_ff;
   assign mx      = cfg.orientation[ORIENT_MIRROR_X] ? (scr_x_v - ox) : ox;
   assign my      = cfg.orientation[ORIENT_MIRROR_Y] ? (scr_y_v - oy) : oy;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (job_avail) begin
               state_in = job_ok ? B_AVG : B_EMIT;
            end
         end
         B_AVG: begin
            if (div_done) begin
               state_in = B_MUL;
            end
         end
         B_MUL:    state_in = B_DIV;
         B_DIV:    state_in = B_WAIT;
         B_WAIT: begin
            if (div_done) begin
               state_in = B_ORIENT;
            end
         end
         B_ORIENT: state_in = B_EMIT;
         B_EMIT: begin
            if (out_free) begin
               state_in = B_IDLE;
            end
         end
         default:  state_in = B_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      job_rd_en          = 1'b0;
      div_x_req.start    = 1'b0;
      div_x_req.steps    = DIV_CNT_W'(SUM_W);
      div_x_req.dividend = {job_rd_data.sum_x, {(DIV_W-SUM_W){1'b0}}};
      div_x_req.divisor  = REG_W'(job_rd_data.count);
      div_y_req.start    = 1'b0;
      div_y_req.steps    = DIV_CNT_W'(SUM_W);
      div_y_req.dividend = {job_rd_data.sum_y, {(DIV_W-SUM_W){1'b0}}};
      div_y_req.divisor  = REG_W'(job_rd_data.count);
      case (state_ff)
         B_IDLE: begin
            job_rd_en       = job_avail;
            div_x_req.start = job_avail && job_ok;
            div_y_req.start = job_avail && job_ok;
         end
         B_DIV: begin
            div_x_req.start    = 1'b1;
            div_x_req.steps    = DIV_CNT_W'(DIV_W);
            div_x_req.dividend = mag_x;
            div_x_req.divisor  = x_range;
            div_y_req.start    = 1'b1;
            div_y_req.steps    = DIV_CNT_W'(DIV_W);
            div_y_req.dividend = mag_y;
            div_y_req.divisor  = y_range;
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      avg_x_in       = avg_x_ff;
      avg_y_in       = avg_y_ff;
      prod_x_in      = prod_x_ff;
      prod_y_in      = prod_y_ff;
      sx_in          = sx_ff;
      sy_in          = sy_ff;
      res_pressed_in = res_pressed_ff;
      res_x_in       = res_x_ff;
      res_y_in       = res_y_ff;
      case (state_ff)
         B_IDLE: begin
            // released, or pressed with no usable average or calibration: point at origin
            res_pressed_in = (job_rd_data.kind == JOB_POSITION);
            res_x_in       = '0;
            res_y_in       = '0;
         end
         B_AVG: begin
            avg_x_in = div_x_rsp.quotient[SAMPLE_BITS-1:0];
            avg_y_in = div_y_rsp.quotient[SAMPLE_BITS-1:0];
         end
         B_MUL: begin
            prod_x_in = diff_x * scr_x_s;
            prod_y_in = diff_y * scr_y_s;
         end
         B_WAIT: begin
            sx_in = prod_x_ff[PROD_W-1] ? -qx : qx;
            sy_in = prod_y_ff[PROD_W-1] ? -qy : qy;
         end
         B_ORIENT: begin
            res_pressed_in = 1'b1;
            res_x_in       = clamp_to(mx, cfg.screen_x_max);
            res_y_in       = clamp_to(my, cfg.screen_y_max);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (state_ff == B_EMIT && out_free) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      avg_x_ff       <= avg_x_in;
      avg_y_ff       <= avg_y_in;
      prod_x_ff      <= prod_x_in;
      prod_y_ff      <= prod_y_in;
      sx_ff          <= sx_in;
      sy_ff          <= sy_in;
      res_pressed_ff <= res_pressed_in;
      res_x_ff       <= res_x_in;
      res_y_ff       <= res_y_in;
      if (state_ff == B_EMIT && out_free) begin
         out_pressed_ff <= res_pressed_ff;
         out_x_ff       <= res_x_ff;
         out_y_ff       <= res_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign empty       = !out_valid_ff;
   assign rsp_pressed = out_pressed_ff;
   assign rsp_point_x = out_x_ff;
   assign rsp_point_y = out_y_ff;

   `TSC_ASSERT_IMP(a_div_busy_in_wait, div_x_rsp.busy || div_y_rsp.busy, state_ff == B_AVG || state_ff == B_WAIT)
   `TSC_ASSERT_IMP(a_released_at_origin, out_valid_ff && !out_pressed_ff, out_x_ff == '0 && out_y_ff == '0)
   `TSC_ASSERT_NXT(a_emit_holds, state_ff == B_EMIT && out_valid_ff && !pop, state_ff == B_EMIT)

endmodule

// ----- rtl/touch_sample_conditioner_top.sv -----
// ----------------------------------------------------------------------------
// touch_sample_conditioner_top
// Resistive touch sample averaging and calibration, with register bank.
// ----------------------------------------------------------------------------
//  channel  | ports                               | transaction
//  ---------+-------------------------------------+------------------------------
//  request  | push, full, req_raw_x/y             | push && !full
//  response | empty, pop, rsp_pressed, rsp_point_*| pop && !empty
//  csr      | csr_wr_en, csr_index, csr_wdata     | csr_wr_en, no wait state
//
//  The front end takes one sample per clock while the two-entry job queue has room.
//  A released or origin job goes from the idle state straight to emit; a position
//  job runs through the bit-serial dividers, X and Y side by side: 15 quotient
//  bits for the averages, then 24 for the scaling.
//  Reset is synchronous; no clearing pass. A held response only stalls the
//  back end, and the request side stalls only once the job queue is full.
// ----------------------------------------------------------------------------
module touch_sample_conditioner_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic [tsc_pkg::SAMPLE_BITS-1:0]    req_raw_x,
   input  logic [tsc_pkg::SAMPLE_BITS-1:0]    req_raw_y,
   output logic                               empty,
   input  logic                               pop,
   output logic                               rsp_pressed,
   output logic [tsc_pkg::REG_W-1:0]          rsp_point_x,
   output logic [tsc_pkg::REG_W-1:0]          rsp_point_y,
   input  logic                               csr_wr_en,
   input  logic [tsc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tsc_pkg::REG_W-1:0]          csr_wdata
);
   import tsc_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic        job_wr_en;
   job_type     job_wr_data;
   logic        job_full;
   logic        job_rd_en;
   job_type     job_rd_data;
   logic        job_empty;
   div_req_type div_x_req;
   div_rsp_type div_x_rsp;
   div_req_type div_y_req;
   div_rsp_type div_y_rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_CAL_X_MIN:    cfg_in.cal_x_min    = csr_wdata;
            CSR_CAL_Y_MIN:    cfg_in.cal_y_min    = csr_wdata;
            CSR_CAL_X_MAX:    cfg_in.cal_x_max    = csr_wdata;
            CSR_CAL_Y_MAX:    cfg_in.cal_y_max    = csr_wdata;
            CSR_SCREEN_X_MAX: cfg_in.screen_x_max = csr_wdata;
            CSR_SCREEN_Y_MAX: cfg_in.screen_y_max = csr_wdata;
            CSR_ORIENTATION:  cfg_in.orientation  = csr_wdata[ORIENT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cal_x_min    <= CAL_MIN_RESET;
         cfg_ff.cal_y_min    <= CAL_MIN_RESET;
         cfg_ff.cal_x_max    <= CAL_MAX_RESET;
         cfg_ff.cal_y_max    <= CAL_MAX_RESET;
         cfg_ff.screen_x_max <= SCREEN_X_MAX_RESET;
         cfg_ff.screen_y_max <= SCREEN_Y_MAX_RESET;
         cfg_ff.orientation  <= ORIENT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tsc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_raw_x   (req_raw_x),
      .req_raw_y   (req_raw_y),
      .job_wr_en   (job_wr_en),
      .job_wr_data (job_wr_data),
      .job_full    (job_full)
   );

   tsc_job_fifo u_job_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_wr_en),
      .wr_data (job_wr_data),
      .full    (job_full),
      .rd_en   (job_rd_en),
      .rd_data (job_rd_data),
      .empty   (job_empty)
   );

   tsc_divider u_div_x (
      .clock (clock),
      .reset (reset),
      .req   (div_x_req),
      .rsp   (div_x_rsp)
   );

   tsc_divider u_div_y (
      .clock (clock),
      .reset (reset),
      .req   (div_y_req),
      .rsp   (div_y_rsp)
   );

   tsc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .job_rd_data (job_rd_data),
      .job_empty   (job_empty),
      .job_rd_en   (job_rd_en),
      .div_x_req   (div_x_req),
      .div_x_rsp   (div_x_rsp),
      .div_y_req   (div_y_req),
      .div_y_rsp   (div_y_rsp),
      .empty       (empty),
      .pop         (pop),
      .rsp_pressed (rsp_pressed),
      .rsp_point_x (rsp_point_x),
      .rsp_point_y (rsp_point_y)
   );

endmodule
